// ----- hw/rtl/ptc_pkg.sv -----
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared constants, register codes and the CRC-4 step used by the pressure
// and temperature compensation pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

   // datapath stage count, from input register to output register
   localparam int NUM_STAGES = 9;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FACTORY_CRC_WORD      = 3'd0,
      CSR_PRESSURE_SENSITIVITY  = 3'd1,
      CSR_PRESSURE_OFFSET       = 3'd2,
      CSR_TEMP_COEF_SENSITIVITY = 3'd3,
      CSR_TEMP_COEF_OFFSET      = 3'd4,
      CSR_REFERENCE_TEMPERATURE = 3'd5,
      CSR_TEMP_COEF_TEMPERATURE = 3'd6
   } csr_reg_type;

   // scaling shifts of the compensation formulae
   localparam int TEMP_SHIFT  = 23;
   localparam int OFF_SHIFT   = 7;
   localparam int SENS_SHIFT  = 8;
   localparam int PROD_SHIFT  = 21;
   localparam int PRES_SHIFT  = 13;

   // temperature thresholds, hundredths of a degree
   localparam logic signed [18:0] TEMP_BASE  = 19'sd2000;
   localparam logic signed [18:0] TEMP_VLOW  = 19'sd1500;

   // crc over the calibration words
   localparam logic [15:0] CRC_POLY      = 16'h3000;
   localparam logic [15:0] CRC_DATA_MASK = 16'h0FFF;
   localparam int          CRC_BYTES     = 16;
   localparam int          CRC_CNT_W     = $clog2(CRC_BYTES);

   // one byte into the remainder, eight bit steps
   function automatic logic [15:0] crc_feed(logic [15:0] rem, logic [7:0] data);
      logic [15:0] r;
      r = rem ^ {8'd0, data};
      for (int b = 0; b < 8; b++) begin
         if (r[15]) begin
            r = {r[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/ptc_req_if.sv -----
// ----------------------------------------------------------------------------
// ptc_req_if
// Request channel: one pair of raw pressure and temperature conversions.
// ----------------------------------------------------------------------------
interface ptc_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] pressure_raw;
   logic [23:0] temperature_raw;

   modport source (output valid, output pressure_raw, output temperature_raw, input ready);
   modport sink   (input valid, input pressure_raw, input temperature_raw, output ready);
endinterface

// ----- hw/rtl/ptc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ptc_rsp_if
// Response channel: compensated pressure, temperature and calibration check.
// ----------------------------------------------------------------------------
interface ptc_rsp_if;
   logic               valid;
   logic               ready;
   logic        [31:0] pressure;
   logic signed [31:0] temperature;
   logic               calib_crc_ok;

   modport source (output valid, output pressure, output temperature,
                   output calib_crc_ok, input ready);
   modport sink   (input valid, input pressure, input temperature,
                   input calib_crc_ok, output ready);
endinterface

// ----- hw/rtl/pressure_temperature_compensation_top.sv -----
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_top
// Second-order pressure sensor compensation in a nine-stage pipeline, with a
// CRC-4 check of the calibration words.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                     | handshake
//  req_ch   | in  | pressure_raw, temperature_raw (24b each)    | valid/ready
//  rsp_ch   | out | pressure, temperature (32b), calib_crc_ok   | valid/ready
//  csr_*    | in  | csr_index (3b), csr_wdata (16b)             | csr_we only
//
//  one request per cycle while no crc pass runs and the pipeline is not stalled;
//  each passes through nine register stages (the 24 x 39 bit product is split over two)
//  after reset and after every csr write the crc is rebuilt, one byte a
//  cycle: req_ch.ready stays low until the pass ends
//  a full stage holds only while the stage after it cannot load, so bubbles
//  close up and, with a stage empty, a request is taken while a finished response waits
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_top (
   input  logic                              clock,
   input  logic                              reset,
   ptc_req_if.sink                           req_ch,
   ptc_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [ptc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ptc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int N = ptc_pkg::NUM_STAGES;

   localparam logic signed [41:0] MT_BIAS   = (42'sd1 <<< ptc_pkg::TEMP_SHIFT) - 42'sd1;
   localparam logic signed [41:0] MO_BIAS   = (42'sd1 <<< ptc_pkg::OFF_SHIFT) - 42'sd1;
   localparam logic signed [41:0] MS_BIAS   = (42'sd1 <<< ptc_pkg::SENS_SHIFT) - 42'sd1;
   localparam logic signed [62:0] PROD_BIAS = (63'sd1 <<< ptc_pkg::PROD_SHIFT) - 63'sd1;
   localparam logic signed [42:0] PRES_BIAS = (43'sd1 <<< ptc_pkg::PRES_SHIFT) - 43'sd1;

   // ------------------------------------------------------------------------
   // calibration registers
   // ------------------------------------------------------------------------
   logic [15:0] factory_crc_word_ff;
   logic [15:0] pressure_sensitivity_ff;
   logic [15:0] pressure_offset_ff;
   logic [15:0] temp_coef_sensitivity_ff;
   logic [15:0] temp_coef_offset_ff;
   logic [15:0] reference_temperature_ff;
   logic [15:0] temp_coef_temperature_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         factory_crc_word_ff      <= '0;
         pressure_sensitivity_ff  <= '0;
         pressure_offset_ff       <= '0;
         temp_coef_sensitivity_ff <= '0;
         temp_coef_offset_ff      <= '0;
         reference_temperature_ff <= '0;
         temp_coef_temperature_ff <= '0;
      end else if (csr_we) begin
         case (ptc_pkg::csr_reg_type'(csr_index))
            ptc_pkg::CSR_FACTORY_CRC_WORD:      factory_crc_word_ff      <= csr_wdata;
            ptc_pkg::CSR_PRESSURE_SENSITIVITY:  pressure_sensitivity_ff  <= csr_wdata;
            ptc_pkg::CSR_PRESSURE_OFFSET:       pressure_offset_ff       <= csr_wdata;
            ptc_pkg::CSR_TEMP_COEF_SENSITIVITY: temp_coef_sensitivity_ff <= csr_wdata;
            ptc_pkg::CSR_TEMP_COEF_OFFSET:      temp_coef_offset_ff      <= csr_wdata;
            ptc_pkg::CSR_REFERENCE_TEMPERATURE: reference_temperature_ff <= csr_wdata;
            ptc_pkg::CSR_TEMP_COEF_TEMPERATURE: temp_coef_temperature_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // crc-4 over the calibration words, one byte a cycle
   // ------------------------------------------------------------------------
   logic                          crc_busy_ff, crc_busy_in;
   logic [ptc_pkg::CRC_CNT_W-1:0] crc_cnt_ff, crc_cnt_in;
   logic [15:0]                   crc_rem_ff, crc_rem_in;
   logic                          crc_ok_ff, crc_ok_in;
   logic [15:0]                   crc_word;
   logic [7:0]                    crc_byte;

   always_comb begin
      case (crc_cnt_ff[ptc_pkg::CRC_CNT_W-1:1])
         3'd0:    crc_word = factory_crc_word_ff & ptc_pkg::CRC_DATA_MASK;
         3'd1:    crc_word = pressure_sensitivity_ff;
         3'd2:    crc_word = pressure_offset_ff;
         3'd3:    crc_word = temp_coef_sensitivity_ff;
         3'd4:    crc_word = temp_coef_offset_ff;
         3'd5:    crc_word = reference_temperature_ff;
         3'd6:    crc_word = temp_coef_temperature_ff;
         default: crc_word = '0;
      endcase
      // high byte first
      crc_byte = crc_cnt_ff[0] ? crc_word[7:0] : crc_word[15:8];
   end

   always_comb begin
      crc_busy_in = crc_busy_ff;
      crc_cnt_in  = crc_cnt_ff;
      crc_rem_in  = crc_rem_ff;
      crc_ok_in   = crc_ok_ff;
      if (csr_we) begin
         crc_busy_in = 1'b1;
         crc_cnt_in  = '0;
         crc_rem_in  = '0;
      end else if (crc_busy_ff) begin
         crc_rem_in = ptc_pkg::crc_feed(crc_rem_ff, crc_byte);
         crc_cnt_in = crc_cnt_ff + 1'b1;
         if (crc_cnt_ff == ptc_pkg::CRC_CNT_W'(ptc_pkg::CRC_BYTES - 1)) begin
            crc_busy_in = 1'b0;
            crc_ok_in   = (crc_rem_in[15:12] == factory_crc_word_ff[15:12]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_busy_ff <= 1'b1;
         crc_cnt_ff  <= '0;
         crc_rem_ff  <= '0;
         crc_ok_ff   <= 1'b0;
      end else begin
         crc_busy_ff <= crc_busy_in;
         crc_cnt_ff  <= crc_cnt_in;
         crc_rem_ff  <= crc_rem_in;
         crc_ok_ff   <= crc_ok_in;
      end
   end

   // ------------------------------------------------------------------------
   // pipeline control: a stage loads when empty or when the next one moves
   // ------------------------------------------------------------------------
   logic [N:1] stage_v_ff;
   logic [N:1] stage_en;

   always_comb begin
      stage_en[N] = !stage_v_ff[N] || rsp_ch.ready;
      for (int k = N - 1; k >= 1; k--) begin
         stage_en[k] = !stage_v_ff[k] || stage_en[k+1];
      end
   end

   assign req_ch.ready = stage_en[1] && !crc_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= '0;
      end else begin
         if (stage_en[1]) begin
            stage_v_ff[1] <= req_ch.valid && !crc_busy_ff;
         end
         for (int k = 2; k <= N; k++) begin
            if (stage_en[k]) begin
               stage_v_ff[k] <= stage_v_ff[k-1];
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // stage 1: dT
   // ------------------------------------------------------------------------
   logic        [23:0] s1_d1_ff;
   logic signed [24:0] s1_dt_ff, s1_dt_in;

   assign s1_dt_in = $signed({1'b0, req_ch.temperature_raw})
                   - $signed({1'b0, reference_temperature_ff, 8'd0});

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s1_d1_ff <= req_ch.pressure_raw;
         s1_dt_ff <= s1_dt_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 2: coefficient products and dT squared
   // ------------------------------------------------------------------------
   logic        [23:0] s2_d1_ff;
   logic signed [41:0] s2_mt_ff, s2_mt_in;
   logic signed [41:0] s2_mo_ff, s2_mo_in;
   logic signed [41:0] s2_ms_ff, s2_ms_in;
   logic signed [49:0] s2_dtsq_full;
   logic        [47:0] s2_dtsq_ff, s2_dtsq_in;

   always_comb begin
      s2_mt_in     = s1_dt_ff * $signed({1'b0, temp_coef_temperature_ff});
      s2_mo_in     = s1_dt_ff * $signed({1'b0, temp_coef_offset_ff});
      s2_ms_in     = s1_dt_ff * $signed({1'b0, temp_coef_sensitivity_ff});
      s2_dtsq_full = s1_dt_ff * s1_dt_ff;
      s2_dtsq_in   = s2_dtsq_full[47:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s2_d1_ff   <= s1_d1_ff;
         s2_mt_ff   <= s2_mt_in;
         s2_mo_ff   <= s2_mo_in;
         s2_ms_ff   <= s2_ms_in;
         s2_dtsq_ff <= s2_dtsq_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 3: TEMP, OFF, SENS and both candidate Ti
   // ------------------------------------------------------------------------
   logic        [23:0] s3_d1_ff;
   logic signed [41:0] s3_mt_adj, s3_mt_q;
   logic signed [41:0] s3_mo_adj, s3_mo_q;
   logic signed [41:0] s3_ms_adj, s3_ms_q;
   logic        [49:0] s3_dtsq3;
   logic signed [18:0] s3_temp_ff, s3_temp_in;
   logic signed [34:0] s3_off_ff, s3_off_in;
   logic signed [33:0] s3_sens_ff, s3_sens_in;
   logic        [16:0] s3_ti_lo_ff, s3_ti_lo_in;
   logic        [11:0] s3_ti_hi_ff, s3_ti_hi_in;

   always_comb begin
      // signed shifts with a bias so that the quotient truncates toward zero
      s3_mt_adj = s2_mt_ff + (s2_mt_ff[41] ? MT_BIAS : 42'sd0);
      s3_mt_q   = s3_mt_adj >>> ptc_pkg::TEMP_SHIFT;
      s3_mo_adj = s2_mo_ff + (s2_mo_ff[41] ? MO_BIAS : 42'sd0);
      s3_mo_q   = s3_mo_adj >>> ptc_pkg::OFF_SHIFT;
      s3_ms_adj = s2_ms_ff + (s2_ms_ff[41] ? MS_BIAS : 42'sd0);
      s3_ms_q   = s3_ms_adj >>> ptc_pkg::SENS_SHIFT;

      s3_temp_in = $signed(s3_mt_q[18:0]) + ptc_pkg::TEMP_BASE;
      s3_off_in  = $signed({3'd0, pressure_offset_ff, 16'd0}) + $signed(s3_mo_q[34:0]);
      s3_sens_in = $signed({3'd0, pressure_sensitivity_ff, 15'd0}) + $signed(s3_ms_q[33:0]);

      // dT squared is never negative: plain shifts
      s3_dtsq3    = {1'b0, s2_dtsq_ff, 1'b0} + {2'd0, s2_dtsq_ff};
      s3_ti_lo_in = s3_dtsq3[49:33];
      s3_ti_hi_in = s2_dtsq_ff[47:36];
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s3_d1_ff    <= s2_d1_ff;
         s3_temp_ff  <= s3_temp_in;
         s3_off_ff   <= s3_off_in;
         s3_sens_ff  <= s3_sens_in;
         s3_ti_lo_ff <= s3_ti_lo_in;
         s3_ti_hi_ff <= s3_ti_hi_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 4: range decision and squares of the temperature deltas
   // ------------------------------------------------------------------------
   logic        [23:0] s4_d1_ff;
   logic signed [18:0] s4_temp_ff;
   logic signed [34:0] s4_off_ff;
   logic signed [33:0] s4_sens_ff;
   logic signed [18:0] s4_dtemp, s4_dv;
   logic signed [37:0] s4_sqt_full, s4_sqdv_full;
   logic        [35:0] s4_sqt_ff, s4_sqt_in;
   logic        [35:0] s4_sqdv_ff, s4_sqdv_in;
   logic               s4_low_ff, s4_low_in;
   logic               s4_vlow_ff, s4_vlow_in;
   logic        [16:0] s4_ti_ff, s4_ti_in;

   always_comb begin
      s4_dtemp     = s3_temp_ff - ptc_pkg::TEMP_BASE;
      s4_dv        = s3_temp_ff + ptc_pkg::TEMP_VLOW;
      s4_sqt_full  = s4_dtemp * s4_dtemp;
      s4_sqdv_full = s4_dv * s4_dv;
      s4_sqt_in    = s4_sqt_full[35:0];
      s4_sqdv_in   = s4_sqdv_full[35:0];
      s4_low_in    = s3_temp_ff < ptc_pkg::TEMP_BASE;
      s4_vlow_in   = s3_temp_ff < -ptc_pkg::TEMP_VLOW;
      s4_ti_in     = s4_low_in ? s3_ti_lo_ff : {5'd0, s3_ti_hi_ff};
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s4_d1_ff   <= s3_d1_ff;
         s4_temp_ff <= s3_temp_ff;
         s4_off_ff  <= s3_off_ff;
         s4_sens_ff <= s3_sens_ff;
         s4_sqt_ff  <= s4_sqt_in;
         s4_sqdv_ff <= s4_sqdv_in;
         s4_low_ff  <= s4_low_in;
         s4_vlow_ff <= s4_vlow_in;
         s4_ti_ff   <= s4_ti_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 5: OFFi, SENSi and the final temperature
   // ------------------------------------------------------------------------
   logic        [23:0] s5_d1_ff;
   logic signed [34:0] s5_off_ff;
   logic signed [33:0] s5_sens_ff;
   logic        [37:0] s5_sqt3;
   logic        [38:0] s5_sqt5;
   logic        [38:0] s5_dv7;
   logic        [37:0] s5_dv4;
   logic        [37:0] s5_offi_ff, s5_offi_in;
   logic        [37:0] s5_sensi_ff, s5_sensi_in;
   logic signed [19:0] s5_tdiff;
   logic signed [23:0] s5_t_ff, s5_t_in;

   always_comb begin
      s5_sqt3 = {1'b0, s4_sqt_ff, 1'b0} + {2'd0, s4_sqt_ff};
      s5_sqt5 = {1'b0, s4_sqt_ff, 2'd0} + {3'd0, s4_sqt_ff};
      s5_dv7  = {s4_sqdv_ff, 3'd0} - {3'd0, s4_sqdv_ff};
      s5_dv4  = {s4_sqdv_ff, 2'd0};
      if (s4_low_ff) begin
         s5_offi_in  = {1'b0, s5_sqt3[37:1]} + (s4_vlow_ff ? s5_dv7[37:0] : 38'd0);
         s5_sensi_in = {2'd0, s5_sqt5[38:3]} + (s4_vlow_ff ? s5_dv4 : 38'd0);
      end else begin
         s5_offi_in  = {6'd0, s4_sqt_ff[35:4]};
         s5_sensi_in = '0;
      end
      // times ten as eight plus two
      s5_tdiff = $signed({s4_temp_ff[18], s4_temp_ff}) - $signed({3'd0, s4_ti_ff});
      s5_t_in  = $signed({s5_tdiff[19], s5_tdiff, 3'd0})
               + $signed({{3{s5_tdiff[19]}}, s5_tdiff, 1'b0});
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         s5_d1_ff    <= s4_d1_ff;
         s5_off_ff   <= s4_off_ff;
         s5_sens_ff  <= s4_sens_ff;
         s5_offi_ff  <= s5_offi_in;
         s5_sensi_ff <= s5_sensi_in;
         s5_t_ff     <= s5_t_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 6: OFF2 and SENS2
   // ------------------------------------------------------------------------
   logic        [23:0] s6_d1_ff;
   logic signed [23:0] s6_t_ff;
   logic signed [39:0] s6_off2_ff, s6_off2_in;
   logic signed [38:0] s6_sens2_ff, s6_sens2_in;

   always_comb begin
      s6_off2_in  = $signed({{5{s5_off_ff[34]}}, s5_off_ff}) - $signed({2'd0, s5_offi_ff});
      s6_sens2_in = $signed({{5{s5_sens_ff[33]}}, s5_sens_ff}) - $signed({1'b0, s5_sensi_ff});
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         s6_d1_ff    <= s5_d1_ff;
         s6_t_ff     <= s5_t_ff;
         s6_off2_ff  <= s6_off2_in;
         s6_sens2_ff <= s6_sens2_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 7: D1 x SENS2 as two partial products
   // ------------------------------------------------------------------------
   logic signed [23:0] s7_t_ff;
   logic signed [39:0] s7_off2_ff;
   logic        [43:0] s7_plo_ff, s7_plo_in;
   logic signed [43:0] s7_phi_ff, s7_phi_in;

   always_comb begin
      s7_plo_in = s6_d1_ff * s6_sens2_ff[19:0];
      s7_phi_in = $signed({1'b0, s6_d1_ff}) * $signed(s6_sens2_ff[38:20]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         s7_t_ff    <= s6_t_ff;
         s7_off2_ff <= s6_off2_ff;
         s7_plo_ff  <= s7_plo_in;
         s7_phi_ff  <= s7_phi_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 8: recombine and divide by 2^21
   // ------------------------------------------------------------------------
   logic signed [23:0] s8_t_ff;
   logic signed [39:0] s8_off2_ff;
   logic signed [62:0] s8_prod, s8_prod_adj, s8_prod_q;
   logic signed [41:0] s8_q_ff, s8_q_in;

   always_comb begin
      s8_prod     = $signed({s7_phi_ff[42:0], 20'd0}) + $signed({19'd0, s7_plo_ff});
      s8_prod_adj = s8_prod + (s8_prod[62] ? PROD_BIAS : 63'sd0);
      s8_prod_q   = s8_prod_adj >>> ptc_pkg::PROD_SHIFT;
      s8_q_in     = s8_prod_q[41:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[8]) begin
         s8_t_ff    <= s7_t_ff;
         s8_off2_ff <= s7_off2_ff;
         s8_q_ff    <= s8_q_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 9: subtract OFF2, divide by 2^13, output register
   // ------------------------------------------------------------------------
   logic signed [42:0] s9_r, s9_r_adj, s9_r_q;
   logic        [31:0] s9_pressure_ff, s9_pressure_in;
   logic signed [31:0] s9_temperature_ff, s9_temperature_in;
   logic               s9_crc_ok_ff;

   always_comb begin
      s9_r              = $signed({s8_q_ff[41], s8_q_ff})
                        - $signed({{3{s8_off2_ff[39]}}, s8_off2_ff});
      s9_r_adj          = s9_r + (s9_r[42] ? PRES_BIAS : 43'sd0);
      s9_r_q            = s9_r_adj >>> ptc_pkg::PRES_SHIFT;
      s9_pressure_in    = s9_r_q[31:0];
      s9_temperature_in = {{8{s8_t_ff[23]}}, s8_t_ff};
   end

   always_ff @(posedge clock) begin
      if (stage_en[9]) begin
         s9_pressure_ff    <= s9_pressure_in;
         s9_temperature_ff <= s9_temperature_in;
         s9_crc_ok_ff      <= crc_ok_ff;
      end
   end

   assign rsp_ch.valid        = stage_v_ff[N];
   assign rsp_ch.pressure     = s9_pressure_ff;
   assign rsp_ch.temperature  = s9_temperature_ff;
   assign rsp_ch.calib_crc_ok = s9_crc_ok_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_no_request_during_crc: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |-> !crc_busy_ff)
      else $error("request taken while crc rebuild in progress");

   a_csr_restarts_crc: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> crc_busy_ff && crc_cnt_ff == '0)
      else $error("csr write did not restart the crc pass");

   a_crc_pass_ends: assert property (@(posedge clock) disable iff (reset)
      crc_busy_ff && !csr_we
      && crc_cnt_ff == ptc_pkg::CRC_CNT_W'(ptc_pkg::CRC_BYTES - 1) |=> !crc_busy_ff)
      else $error("crc pass did not finish after the last byte");

   a_output_fed_by_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(stage_v_ff[N]) |-> $past(stage_v_ff[N-1]))
      else $error("response appeared without a request in the stage before");

   a_very_low_is_low: assert property (@(posedge clock) disable iff (reset)
      stage_v_ff[4] && s4_vlow_ff |-> s4_low_ff)
      else $error("very low range flagged outside the low range");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives raw pressure/temperature pairs through the compensation pipeline
// under several sets of calibration words, including all-zero, all-ones and
// CRC-matching sets. Each response is checked field by field against a typed
// row or an in-bench 64-bit model of the second-order compensation and CRC-4 check.
// ----------------------------------------------------------------------------
module tb_top;
   import ptc_pkg::*;

   localparam int NUM_CAL_WORDS = CSR_TEMP_COEF_TEMPERATURE + 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam longint LOW_TI_DIV  = 64'sd8589934592;
   localparam longint HIGH_TI_DIV = 64'sd137438953472;
   localparam int NUM_DIRECTED = 12;

   typedef logic [NUM_CAL_WORDS-1:0][15:0] cal_set_t;

   typedef struct packed {
      logic        [31:0] pressure;
      logic signed [31:0] temperature;
      logic               crc_ok;
   } comp_reading_t;

   typedef struct packed {
      logic [23:0]   p_raw;
      logic [23:0]   t_raw;
      bit            typed;
      comp_reading_t want;
   } sample_row_t;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_EVERY_THIRD} stall_mode_t;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ptc_req_if req_ch ();
   ptc_rsp_if rsp_ch ();

   pressure_temperature_compensation_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cal_set_t      calib;
   cal_set_t      staged;
   comp_reading_t pending_readings [$];
   bit            offer_typed;
   comp_reading_t offer_want;
   int            mismatches;
   int            responses_seen;
   int            burst_left;

   // typed rows hold for all-zero calibration only
   sample_row_t directed_rows [NUM_DIRECTED] = '{
      '{24'h000000, 24'h000000, 1'b1, '{32'd0, 32'sd20000, 1'b1}},
      '{24'hFFFFFF, 24'hFFFFFF, 1'b1, '{32'd0, -32'sd20950, 1'b1}},
      '{24'hFFFFFF, 24'h000000, 1'b1, '{32'd0, 32'sd20000, 1'b1}},
      '{24'h000000, 24'hFFFFFF, 1'b1, '{32'd0, -32'sd20950, 1'b1}},
      '{24'h800000, 24'h000001, 1'b1, '{32'd0, 32'sd20000, 1'b1}},
      '{24'h800000, 24'd6656000, 1'b0, '0},
      '{24'h123456, 24'd6655700, 1'b0, '0},
      '{24'hABCDEF, 24'd6000000, 1'b0, '0},
      '{24'h5A5A5A, 24'd5607424, 1'b0, '0},
      '{24'hA5A5A5, 24'd5607124, 1'b0, '0},
      '{24'h7FFFFF, 24'd4000000, 1'b0, '0},
      '{24'h000001, 24'd8000000, 1'b0, '0}
   };

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [3:0] calib_crc4(input cal_set_t words);
      logic [15:0] rem;
      logic [15:0] w;
      logic [7:0]  octet;
      rem = '0;
      for (int i = 0; i < 2 * (NUM_CAL_WORDS + 1); i++) begin
         // word 0 without its stored nibble, then words 1..6, then a zero word
         if (i / 2 == CSR_FACTORY_CRC_WORD) begin
            w = words[CSR_FACTORY_CRC_WORD] & CRC_DATA_MASK;
         end else if (i / 2 == NUM_CAL_WORDS) begin
            w = '0;
         end else begin
            w = words[i / 2];
         end
         octet = (i % 2 == 0) ? w[15:8] : w[7:0];
         rem[7:0] = rem[7:0] ^ octet;
         for (int b = 0; b < 8; b++) begin
            rem = rem[15] ? ({rem[14:0], 1'b0} ^ CRC_POLY) : {rem[14:0], 1'b0};
         end
      end
      return rem[15:12];
   endfunction

   function automatic comp_reading_t compensate(input logic [23:0] p_raw,
                                                input logic [23:0] t_raw);
      comp_reading_t r;
      longint d1, d2, c_sens, c_off, c_tcs, c_tco, c_tref, c_tct;
      longint dt, temp, off, sens, ti, offi, sensi, dtemp, dv, p, t;
      d1 = p_raw;
      d2 = t_raw;
      c_sens = calib[CSR_PRESSURE_SENSITIVITY];
      c_off  = calib[CSR_PRESSURE_OFFSET];
      c_tcs  = calib[CSR_TEMP_COEF_SENSITIVITY];
      c_tco  = calib[CSR_TEMP_COEF_OFFSET];
      c_tref = calib[CSR_REFERENCE_TEMPERATURE];
      c_tct  = calib[CSR_TEMP_COEF_TEMPERATURE];
      dt   = d2 - c_tref * 256;
      temp = 2000 + (dt * c_tct) / 8388608;
      off  = c_off * 65536 + (c_tco * dt) / 128;
      sens = c_sens * 32768 + (c_tcs * dt) / 256;
      dtemp = temp - 2000;
      if (temp < 2000) begin
         ti    = (3 * dt * dt) / LOW_TI_DIV;
         offi  = (3 * dtemp * dtemp) / 2;
         sensi = (5 * dtemp * dtemp) / 8;
         if (temp < -1500) begin
            dv    = temp + 1500;
            offi  = offi + 7 * dv * dv;
            sensi = sensi + 4 * dv * dv;
         end
      end else begin
         ti    = (2 * dt * dt) / HIGH_TI_DIV;
         offi  = (dtemp * dtemp) / 16;
         sensi = 0;
      end
      off  = off - offi;
      sens = sens - sensi;
      t = (temp - ti) * 10;
      p = ((d1 * sens) / 2097152 - off) / 8192;
      r.pressure    = p[31:0];
      r.temperature = t[31:0];
      r.crc_ok      = (calib_crc4(calib) == calib[CSR_FACTORY_CRC_WORD][15:12]);
      return r;
   endfunction

   // response check first, then the new request, so a same-edge pair is ordered
   always @(posedge clock) begin : monitor
      comp_reading_t want;
      if (!reset) begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            responses_seen++;
            if (pending_readings.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response p=%0d t=%0d crc_ok=%0b", $realtime,
                        rsp_ch.pressure, rsp_ch.temperature, rsp_ch.calib_crc_ok);
            end else begin
               want = pending_readings.pop_front();
               if (rsp_ch.pressure !== want.pressure ||
                   rsp_ch.temperature !== want.temperature ||
                   rsp_ch.calib_crc_ok !== want.crc_ok) begin
                  mismatches++;
                  if (mismatches <= 200) begin
                     $display("%0t: mismatch exp p=%0d t=%0d crc_ok=%0b, got p=%0d t=%0d crc_ok=%0b",
                              $realtime, want.pressure, want.temperature, want.crc_ok,
                              rsp_ch.pressure, rsp_ch.temperature, rsp_ch.calib_crc_ok);
                  end
               end
            end
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            pending_readings.push_back(offer_typed ? offer_want :
                                       compensate(req_ch.pressure_raw, req_ch.temperature_raw));
         end
      end
   end

   // response side back-pressure, with long hold-offs to fill the pipeline
   initial begin : rsp_stall
      stall_mode_t mode;
      int mode_left, hold_left, next_hold, phase_cnt;
      rsp_ch.ready = 1'b0;
      mode = STALL_NONE;
      mode_left = 0;
      hold_left = 0;
      next_hold = 400;
      phase_cnt = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && next_hold != 0 && responses_seen >= next_hold) begin
            hold_left = 80;
            next_hold = (next_hold == 400) ? 900 : 0;
         end
         if (mode_left == 0) begin
            mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_EVERY_THIRD));
            mode_left = $urandom_range(10, 80);
         end
         mode_left--;
         phase_cnt++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               STALL_NONE:        rsp_ch.ready <= 1'b1;
               STALL_LIGHT:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
               STALL_HEAVY:       rsp_ch.ready <= ($urandom_range(0, 9) < 3);
               STALL_EVERY_THIRD: rsp_ch.ready <= (phase_cnt % 3 == 0);
               default:           rsp_ch.ready <= 1'b1;
            endcase
         end
      end
   end

   // called at a falling edge; returns at a falling edge
   task automatic sender_gap();
      int gap;
      gap = $urandom_range(1, 8);
      req_ch.valid <= 1'b0;
      req_ch.pressure_raw <= 24'($urandom);
      req_ch.temperature_raw <= 24'($urandom);
      repeat (gap) @(negedge clock);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
   endtask

   task automatic send_request(input logic [23:0] p_raw, input logic [23:0] t_raw,
                               input bit typed, input comp_reading_t want);
      if (burst_left == 0) begin
         sender_gap();
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.pressure_raw <= p_raw;
      req_ch.temperature_raw <= t_raw;
      offer_typed <= typed;
      offer_want <= want;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (pending_readings.size() != 0) @(negedge clock);
   endtask

   task automatic load_calibration(input bit poke_unused);
      wait_idle();
      for (int i = CSR_FACTORY_CRC_WORD; i <= CSR_TEMP_COEF_TEMPERATURE; i++) begin
         csr_we <= 1'b1;
         csr_index <= csr_reg_type'(i);
         csr_wdata <= staged[i];
         calib[i] = staged[i];
         @(negedge clock);
      end
      // a write to an index with no register behind it must change nothing
      if (poke_unused) begin
         csr_we <= 1'b1;
         csr_index <= CSR_UNUSED_INDEX;
         csr_wdata <= 16'($urandom);
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic walk_directed(input bit use_typed);
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_request(directed_rows[i].p_raw, directed_rows[i].t_raw,
                      use_typed && directed_rows[i].typed, directed_rows[i].want);
      end
   endtask

   task automatic run_random(input int count);
      int sel;
      logic [23:0] centre, p_raw, t_raw;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 9);
         centre = {calib[CSR_REFERENCE_TEMPERATURE], 8'h00};
         p_raw = (sel == 0) ? ($urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000) : 24'($urandom);
         case (sel)
            1: t_raw = 24'($urandom);
            2: t_raw = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
            // around the reference point so every temperature range is reached
            default: t_raw = centre + 24'($urandom_range(0, 1 << 22)) - 24'd2097152;
         endcase
         send_request(p_raw, t_raw, 1'b0, '0);
      end
   endtask

   task automatic stage_random(input bit crc_match);
      for (int i = CSR_FACTORY_CRC_WORD; i <= CSR_TEMP_COEF_TEMPERATURE; i++) begin
         staged[i] = 16'($urandom);
      end
      if (crc_match) begin
         staged[CSR_FACTORY_CRC_WORD][15:12] = calib_crc4(staged);
      end
   endtask

   initial begin : timeout
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_FACTORY_CRC_WORD;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.pressure_raw = '0;
      req_ch.temperature_raw = '0;
      offer_typed = 1'b0;
      offer_want = '0;
      calib = '0;
      staged = '0;
      mismatches = 0;
      responses_seen = 0;
      burst_left = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // calibration straight out of reset
      walk_directed(1'b1);
      run_random(100);

      // a plausible sensor with a matching stored crc
      staged[CSR_FACTORY_CRC_WORD]      = 16'h0ABC;
      staged[CSR_PRESSURE_SENSITIVITY]  = 16'd40000;
      staged[CSR_PRESSURE_OFFSET]       = 16'd36000;
      staged[CSR_TEMP_COEF_SENSITIVITY] = 16'd23000;
      staged[CSR_TEMP_COEF_OFFSET]      = 16'd24000;
      staged[CSR_REFERENCE_TEMPERATURE] = 16'd26000;
      staged[CSR_TEMP_COEF_TEMPERATURE] = 16'd28000;
      staged[CSR_FACTORY_CRC_WORD][15:12] = calib_crc4(staged);
      load_calibration(1'b0);
      walk_directed(1'b0);
      run_random(350);

      staged = '1;
      load_calibration(1'b1);
      run_random(200);

      // zero words with a stored nibble that cannot match
      staged = '0;
      staged[CSR_FACTORY_CRC_WORD] = 16'hF000;
      load_calibration(1'b0);
      run_random(120);

      stage_random(1'b1);
      load_calibration(1'b1);
      run_random(190);
      stage_random(1'b0);
      load_calibration(1'b0);
      run_random(190);
      stage_random(1'b1);
      load_calibration(1'b0);
      run_random(190);

      wait_idle();
      repeat (2 * NUM_STAGES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
